// ----- design/sla_pkg.sv -----
package sla_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int FILL_W     = $clog2(LINE_DEPTH);

  localparam logic [7:0] BYTE_CTRL_C = 8'h03;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_CTRL_X = 8'h18;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    EV_ECHO    = 3'd0,
    EV_LINE    = 3'd1,
    EV_ACK     = 3'd2,
    EV_LONG    = 3'd3,
    EV_CANCEL  = 3'd4,
    EV_ERASE   = 3'd5,
    EV_NEWLINE = 3'd6
  } ev_kind_t;

  typedef enum logic [1:0] {
    END_NONE = 2'd0,
    END_CR   = 2'd1,
    END_LF   = 2'd2
  } end_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A,
    S_B,
    S_RD,
    S_LN
  } state_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_A,
    SEL_B,
    SEL_LINE
  } emit_sel_t;

  typedef struct packed {
    logic      ready;
    logic      take;
    emit_sel_t emit_sel;
    logic      rd_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_a;
    logic has_b;
    logic flush_nz;
    logic idx_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/sla_ram.sv -----
module sla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/sla_ctrl.sv -----
module sla_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  sla_pkg::dp_status_t status,
  output sla_pkg::ctrl_cmd_t  cmd
);
  import sla_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_A;
        end
      end
      S_A: begin
        if (status.has_a && !status.out_free) begin
          state_nxt = S_A;
        end else if (status.has_b) begin
          state_nxt = S_B;
        end else if (status.flush_nz) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_B: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_LN;
      end
      S_LN: begin
        if (status.out_free) begin
          state_nxt = status.idx_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.emit_sel = SEL_NONE;
    case (state_r)
      S_IDLE: begin
        cmd.ready = 1'b1;
        cmd.take  = in_valid;
      end
      S_A: begin
        if (status.has_a && status.out_free) begin
          cmd.emit_sel = SEL_A;
        end
      end
      S_B: begin
        if (status.out_free) begin
          cmd.emit_sel = SEL_B;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_LN: begin
        if (status.out_free) begin
          cmd.emit_sel = SEL_LINE;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- design/sla_dpath.sv -----
module sla_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_echo_enable,
  input  logic [7:0]          in_rx_byte,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          out_event_kind,
  output logic [7:0]          out_data_byte,
  output logic                out_stop_request,
  output logic                out_last,
  input  sla_pkg::ctrl_cmd_t  cmd,
  output sla_pkg::dp_status_t status
);
  import sla_pkg::*;

  logic              echo_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  end_code_t         end_r, end_nxt;
  logic              has_a_r, has_a_nxt;
  logic              has_b_r, has_b_nxt;
  ev_kind_t          kind_a_r, kind_a_nxt;
  logic [7:0]        data_a_r, data_a_nxt;
  logic              stop_a_r, stop_a_nxt;
  ev_kind_t          kind_b_r, kind_b_nxt;
  logic [FILL_W-1:0] len_r, len_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  ev_kind_t          out_kind_r, out_kind_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_stop_r, out_stop_nxt;
  logic              out_last_r, out_last_nxt;

  logic       printable;
  logic       is_end;
  end_code_t  code;
  logic       store_wr;
  logic [7:0] rd_data;

  assign printable = (in_rx_byte > BYTE_SPACE) && !in_rx_byte[7];
  assign is_end    = (in_rx_byte == BYTE_CR) || (in_rx_byte == BYTE_LF);
  assign code      = (in_rx_byte == BYTE_CR) ? END_CR : END_LF;
  assign store_wr  = cmd.take && printable;

  sla_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (store_wr),
    .wr_addr(fill_r),
    .wr_data(in_rx_byte),
    .rd_en  (cmd.rd_en),
    .rd_addr(idx_r),
    .rd_data(rd_data)
  );

  // Work out the whole result plan for a byte at the moment it is taken.
  always_comb begin
    fill_nxt   = fill_r;
    end_nxt    = end_r;
    has_a_nxt  = has_a_r;
    has_b_nxt  = has_b_r;
    kind_a_nxt = kind_a_r;
    data_a_nxt = data_a_r;
    stop_a_nxt = stop_a_r;
    kind_b_nxt = kind_b_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    if (cmd.take) begin
      has_a_nxt  = 1'b0;
      has_b_nxt  = 1'b0;
      kind_a_nxt = EV_ECHO;
      data_a_nxt = 8'h00;
      stop_a_nxt = 1'b0;
      kind_b_nxt = EV_LONG;
      len_nxt    = '0;
      idx_nxt    = '0;
      if (printable) begin
        has_a_nxt  = echo_r;
        data_a_nxt = in_rx_byte;
        if (fill_r == FILL_W'(LINE_DEPTH - 1)) begin
          has_b_nxt = 1'b1;
          fill_nxt  = '0;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end else if (is_end) begin
        kind_a_nxt = EV_NEWLINE;
        if (fill_r != '0) begin
          has_a_nxt = echo_r;
          len_nxt   = fill_r;
          fill_nxt  = '0;
          end_nxt   = code;
        end else if (end_r == END_NONE || end_r == code) begin
          has_a_nxt  = echo_r;
          has_b_nxt  = 1'b1;
          kind_b_nxt = EV_ACK;
          end_nxt    = code;
        end else begin
          end_nxt = END_NONE;
        end
      end else if (in_rx_byte == BYTE_CTRL_C || in_rx_byte == BYTE_CTRL_X) begin
        fill_nxt   = '0;
        has_a_nxt  = 1'b1;
        kind_a_nxt = EV_CANCEL;
        data_a_nxt = in_rx_byte;
        stop_a_nxt = (in_rx_byte == BYTE_CTRL_X);
      end else if (in_rx_byte == BYTE_BS && fill_r != '0) begin
        fill_nxt   = fill_r - 1'b1;
        has_a_nxt  = 1'b1;
        kind_a_nxt = EV_ERASE;
      end
    end else if (cmd.emit_sel == SEL_LINE) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // Output register: load on emit, drop once the transaction completes.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_stop_nxt  = out_stop_r;
    out_last_nxt  = out_last_r;
    case (cmd.emit_sel)
      SEL_A: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = kind_a_r;
        out_data_nxt  = data_a_r;
        out_stop_nxt  = stop_a_r;
        out_last_nxt  = !has_b_r && (len_r == '0);
      end
      SEL_B: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = kind_b_r;
        out_data_nxt  = 8'h00;
        out_stop_nxt  = 1'b0;
        out_last_nxt  = 1'b1;
      end
      SEL_LINE: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = EV_LINE;
        out_data_nxt  = rd_data;
        out_stop_nxt  = 1'b0;
        out_last_nxt  = status.idx_last;
      end
      default: begin
        out_kind_nxt = out_kind_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r      <= 1'b1;
      fill_r      <= '0;
      end_r       <= END_NONE;
      has_a_r     <= 1'b0;
      has_b_r     <= 1'b0;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        echo_r <= cfg_echo_enable;
      end
      fill_r      <= fill_nxt;
      end_r       <= end_nxt;
      has_a_r     <= has_a_nxt;
      has_b_r     <= has_b_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_a_r   <= kind_a_nxt;
    data_a_r   <= data_a_nxt;
    stop_a_r   <= stop_a_nxt;
    kind_b_r   <= kind_b_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_stop_r <= out_stop_nxt;
    out_last_r <= out_last_nxt;
  end

  assign status.has_a    = has_a_r;
  assign status.has_b    = has_b_r;
  assign status.flush_nz = (len_r != '0);
  assign status.idx_last = (idx_r == len_r - 1'b1);
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_data_byte    = out_data_r;
  assign out_stop_request = out_stop_r;
  assign out_last         = out_last_r;

endmodule

// ----- design/serial_line_assembler_core.sv -----
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | in_rx_byte
// out     | output    | out_valid / out_stall | out_event_kind, out_data_byte,
//         |           |                       | out_stop_request, out_last
// cfg     | input     | cfg_wr_en             | cfg_echo_enable
//
// A byte passes through the take state and then the decode state. The decode
// state loads the first event (echo, newline, cancel or erase) when there is
// one. An ack or too-long event adds a further state. Each flushed line byte
// passes through a read state and an emit state, since the line store read is
// registered. Ignored bytes pass through only the take and decode states.
// Reset (rst_n low, synchronous) empties the line and enables echo.
// Output stalls hold the sequencer. in_stall is low only in idle, so the next
// byte may be taken while the final result of the previous one still waits.
module serial_line_assembler_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_echo_enable,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_kind,
  output logic [7:0] out_data_byte,
  output logic       out_stop_request,
  output logic       out_last
);
  import sla_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign in_stall = !cmd.ready;

  sla_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .status  (status),
    .cmd     (cmd)
  );

  sla_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_echo_enable (cfg_echo_enable),
    .in_rx_byte      (in_rx_byte),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_event_kind  (out_event_kind),
    .out_data_byte   (out_data_byte),
    .out_stop_request(out_stop_request),
    .out_last        (out_last),
    .cmd             (cmd),
    .status          (status)
  );

endmodule
